/* rtl/core/runmed_pkg.sv */
// Shared types and constants for the running median block.
// No dependencies; imported by the cells, the median select and the top level.
package runmed_pkg;

    // Number of chain entries folded together in the first median select stage.
    localparam int GROUP_SIZE = 8;

    // Per-cell control for one insertion cycle.
    typedef struct packed {
        logic load;      // the chain takes a new sample in this cycle
        logic occupied;  // this cell holds a member of the current set
    } t_cell_ctrl;

endpackage

/* rtl/core/running_median_top.sv */
// Running median top level: sorted chain of cells plus median select.
// Depends on runmed_pkg, runmed_cell and runmed_select.
//
// Each input transaction carries one signed sample and a start_new flag; the
// block answers with exactly one output transaction holding the median of all
// samples since the last restart (the lower middle value for an even count),
// the number of samples now held, and a flag that says the store was full and
// the sample was dropped (median and count then repeat the current set).
// The set lives in a chain of CAPACITY cells kept in ascending order: in the
// cycle a transaction is accepted, every cell compares its entry with the new
// sample and either keeps its value, takes the sample, or takes its lower
// neighbor's value. The median entry is then picked out by a two-stage
// registered select (groups of eight cells, then across the groups), so one
// transaction passes through three steps: accept and insert, group select,
// final select into the output register once that register is free. The
// block takes no new sample until the current one has reached the output
// register. The output register decouples the two sides, so a new sample is
// accepted while a finished result still waits to be taken. No clearing
// pass is needed after reset: only cells below the fill count take part in a
// comparison, and a restart simply sets the fill count to zero.
module running_median_top
    import runmed_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0]                 i_sample,
    input  logic                                   i_start_new,
    // Output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [SAMPLE_BITS-1:0]                 o_median,
    output logic [$clog2(CAPACITY+1)-1:0]          o_held_count,
    output logic                                   o_full_res
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;  // waiting for a sample
    localparam logic [1:0] S_GATHER = 2'd1;  // group select stage loads
    localparam logic [1:0] S_EMIT   = 2'd2;  // final select into output register

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [COUNT_W-1:0] r_count;
    logic [IDX_W-1:0]   r_mid;
    logic               r_dropped;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_median;
    logic [COUNT_W-1:0]     r_held;
    logic                   r_full;

    logic                   w_accept;
    logic [COUNT_W-1:0]     w_base_count;
    logic                   w_is_full;
    logic [COUNT_W-1:0]     w_new_count;
    logic [COUNT_W-1:0]     w_new_last;
    logic                   w_emit;
    logic [SAMPLE_BITS-1:0] w_select_median;

    logic signed [SAMPLE_BITS-1:0]        w_sample;
    logic signed [SAMPLE_BITS-1:0]        w_value [CAPACITY];
    logic                                 w_gt    [CAPACITY];
    logic [CAPACITY-1:0][SAMPLE_BITS-1:0] w_values_flat;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_sample   = i_sample;

    // A restart empties the set before the new sample is considered.
    assign w_base_count = i_start_new ? '0 : r_count;
    assign w_is_full    = (w_base_count == COUNT_W'(CAPACITY));
    assign w_new_count  = w_is_full ? w_base_count : w_base_count + COUNT_W'(1);
    // Index of the last entry; the median sits at half of it, rounded down.
    assign w_new_last   = w_new_count - COUNT_W'(1);

    // Sorted insertion chain.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_cell_ctrl w_ctrl;

        assign w_ctrl.load     = w_accept && !w_is_full;
        assign w_ctrl.occupied = (COUNT_W'(i) < w_base_count);

        if (i == 0) begin : g_head
            runmed_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_sample    (w_sample),
                .i_prev_value(w_sample),
                .i_prev_gt   (1'b0),
                .o_value     (w_value[i]),
                .o_gt        (w_gt[i])
            );
        end else begin : g_body
            runmed_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl),
                .i_sample    (w_sample),
                .i_prev_value(w_value[i-1]),
                .i_prev_gt   (w_gt[i-1]),
                .o_value     (w_value[i]),
                .o_gt        (w_gt[i])
            );
        end

        assign w_values_flat[i] = w_value[i];
    end

    // The select reads the chain in the cycle after insertion, when it has settled.
    runmed_select #(
        .CAPACITY   (CAPACITY),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_select (
        .i_clk   (i_clk),
        .i_load  (r_state == S_GATHER),
        .i_values(w_values_flat),
        .i_mid   (r_mid),
        .o_median(w_select_median)
    );

    // The result leaves the emit state once the output register is free.
    assign w_emit = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= w_new_count;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mid     <= IDX_W'(w_new_last >> 1);
            r_dropped <= w_is_full;
        end
        if (w_emit) begin
            r_median <= w_select_median;
            r_held   <= r_count;
            r_full   <= r_dropped;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_median     = r_median;
    assign o_held_count = r_held;
    assign o_full_res   = r_full;

endmodule

/* rtl/core/runmed_cell.sv */
// One cell of the sorted insertion chain: a single stored sample.
// Depends on runmed_pkg for the cell control struct.
module runmed_cell
    import runmed_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  t_cell_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_value,
    input  logic                          i_prev_gt,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_gt
);

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] n_value;

    // A free cell counts as "greater", so the new sample lands at the first
    // free place when nothing stored exceeds it.
    assign o_gt = !i_ctrl.occupied || (r_value > i_sample);

    // Cells at or above the insertion point shift up by one place; the cell
    // at the insertion point takes the new sample.
    always_comb begin
        if (o_gt) begin
            n_value = i_prev_gt ? i_prev_value : i_sample;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

/* rtl/core/runmed_select.sv */
// Two-stage median select over the insertion chain: registered group ORs,
// then a final OR across the groups. Depends on runmed_pkg for GROUP_SIZE.
module runmed_select
    import runmed_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_load,
    input  logic [CAPACITY-1:0][SAMPLE_BITS-1:0] i_values,
    input  logic [$clog2(CAPACITY)-1:0]          i_mid,
    output logic [SAMPLE_BITS-1:0]               o_median
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PADDED = GROUPS * GROUP_SIZE;

    logic [PADDED-1:0][SAMPLE_BITS-1:0] w_padded;
    logic [GROUPS-1:0][SAMPLE_BITS-1:0] r_group;
    logic [GROUPS-1:0][SAMPLE_BITS-1:0] n_group;

    // Padding entries are zero, so an index that aliases onto them adds nothing.
    always_comb begin
        w_padded = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_padded[i] = i_values[i];
        end
    end

    always_comb begin
        n_group = '0;
        for (int g = 0; g < GROUPS; g++) begin
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (IDX_W'(g * GROUP_SIZE + k) == i_mid) begin
                    n_group[g] = n_group[g] | w_padded[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_group <= n_group;
        end
    end

    always_comb begin
        o_median = '0;
        for (int g = 0; g < GROUPS; g++) begin
            o_median = o_median | r_group[g];
        end
    end

endmodule

/* rtl/core/runmed_checker.sv */
// Port-level checker for the running median block, bound to the top level.
// Depends only on the ports of running_median_top.
module runmed_checker #(
    parameter int CAPACITY    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [SAMPLE_BITS-1:0]        o_median,
    input logic [$clog2(CAPACITY+1)-1:0] o_held_count,
    input logic                          o_full_res
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // A pending result holds until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_median)
            && $stable(o_held_count) && $stable(o_full_res)))
        else $error("output transaction changed while stalled");

    // Every result describes a set that holds at least one sample.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_held_count != '0))
        else $error("result reports an empty set");

    // A dropped sample is only reported when the store is at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> (o_held_count == COUNT_W'(CAPACITY)))
        else $error("full flag with store below capacity");

    // One sample at a time: input closes right after a transaction.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a sample is in flight");

endmodule

bind running_median_top runmed_checker #(
    .CAPACITY   (CAPACITY),
    .SAMPLE_BITS(SAMPLE_BITS)
) u_runmed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_median    (o_median),
    .o_held_count(o_held_count),
    .o_full_res  (o_full_res)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for running_median_top: a directed table, then random sample sets.
// Depends only on the running_median_top RTL; expected medians come from an in-bench sorted store.
module tb;

    localparam int CAP   = 64;
    localparam int SBITS = 16;
    localparam int CNT_W = $clog2(CAP + 1);

    // Random stimulus size and idling behavior.
    localparam int RANDOM_ITEMS    = 420;
    localparam int QUIET_TAIL      = 60;   // last random transactions go out with no idling
    localparam int HOLD_AT_ITEM    = 100;  // receiver starts its long hold-off here
    localparam int DRAIN_AT_ITEM   = 250;  // sender waits for an empty scoreboard here
    localparam int OUT_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int DIRECTED_ROWS   = 18;

    // One result transaction as the block should produce it.
    typedef struct packed {
        logic signed [SBITS-1:0] median;
        logic [CNT_W-1:0]        held_count;
        logic                    full_res;
    } t_median_result;

    // One row of the directed table. A row with reps above one sends the same
    // sample repeatedly; start_new only applies to the first of them. Rows with
    // known set to one carry an expectation typed in by hand.
    typedef struct packed {
        logic [SBITS-1:0]        sample;
        logic                    start_new;
        logic [7:0]              reps;
        logic                    known;
        logic signed [SBITS-1:0] med;
        logic [CNT_W-1:0]        cnt;
        logic                    full;
    } t_stim_row;

    // How the random sample values of one set are spread.
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME
    } t_spread;

    // Clock, reset and block ports. Every input holds a known value from time zero.
    logic                    i_clk;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic [SBITS-1:0]        i_sample     = '0;
    logic                    i_start_new  = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic [SBITS-1:0]        o_median;
    logic [CNT_W-1:0]        o_held_count;
    logic                    o_full_res;

    // Bench-side copy of the sorted store and its fill count.
    logic signed [SBITS-1:0] chain_vals [CAP];
    int                      chain_fill;

    // Medians still owed by the block, oldest first.
    t_median_result          pending_medians [$];

    // Coordination between the sender and the receiver.
    bit                      hold_request = 1'b0;
    bit                      quiet_tail   = 1'b0;

    // Run statistics.
    int                      error_count      = 0;
    int                      samples_sent     = 0;
    int                      restarts_sent    = 0;
    int                      results_checked  = 0;
    int                      drops_seen       = 0;

    // Directed table. The first rows build a small set out of the extreme
    // values, then restarts are checked, then the store is filled with 64
    // equal samples so that the next two samples are dropped, and finally a
    // restart is sent while the store is still full.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{16'h7FFF, 1'b0, 8'd1,  1'b1, 16'sh7FFF, 7'd1,  1'b0},
        '{16'h8000, 1'b0, 8'd1,  1'b1, 16'sh8000, 7'd2,  1'b0},
        '{16'h0000, 1'b0, 8'd1,  1'b1, 16'sh0000, 7'd3,  1'b0},
        '{16'h0000, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'hFFFF, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'h5555, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'hAAAA, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'hFFFF, 1'b1, 8'd1,  1'b1, 16'shFFFF, 7'd1,  1'b0},
        '{16'h0001, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'h7FFF, 1'b1, 8'd1,  1'b1, 16'sh7FFF, 7'd1,  1'b0},
        '{16'h7FFF, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'h8000, 1'b1, 8'd1,  1'b1, 16'sh8000, 7'd1,  1'b0},
        '{16'h8000, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'h0005, 1'b1, 8'd64, 1'b0, 16'sh0000, 7'd0,  1'b0},
        '{16'h7FFF, 1'b0, 8'd1,  1'b1, 16'sh0005, 7'd64, 1'b1},
        '{16'h8000, 1'b0, 8'd1,  1'b1, 16'sh0005, 7'd64, 1'b1},
        '{16'h1234, 1'b1, 8'd1,  1'b1, 16'sh1234, 7'd1,  1'b0},
        '{16'h8000, 1'b0, 8'd1,  1'b0, 16'sh0000, 7'd0,  1'b0}
    };

    running_median_top #(
        .CAPACITY    (CAP),
        .SAMPLE_BITS (SBITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_start_new  (i_start_new),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_median     (o_median),
        .o_held_count (o_held_count),
        .o_full_res   (o_full_res)
    );

    // 125 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Prints one line for a failed check and counts it.
    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Adds one sample to the bench copy of the sorted store and returns the
    // result the block must give for it. A restart empties the store first.
    // A sample that finds the store full is dropped and the current median
    // and count are repeated. An equal value goes in above its equals.
    function automatic t_median_result next_median(input logic signed [SBITS-1:0] s,
                                                   input logic sn);
        t_median_result r;
        int             pos;
        r.full_res = 1'b0;
        if (sn) begin
            chain_fill = 0;
        end
        if (chain_fill >= CAP) begin
            r.full_res = 1'b1;
        end else begin
            pos = chain_fill;
            while (pos > 0 && chain_vals[pos-1] > s) begin
                chain_vals[pos] = chain_vals[pos-1];
                pos--;
            end
            chain_vals[pos] = s;
            chain_fill++;
        end
        r.median     = chain_vals[(chain_fill - 1) / 2];
        r.held_count = CNT_W'(chain_fill);
        return r;
    endfunction

    // Draws one random sample with the given spread.
    function automatic logic [SBITS-1:0] pick_sample(input t_spread spread);
        logic [SBITS-1:0] v;
        case (spread)
            SPREAD_NARROW: begin
                v = SBITS'($urandom_range(0, 8)) - SBITS'(4);
            end
            SPREAD_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h7FFF;
                    1:       v = 16'h8000;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            default: begin
                v = SBITS'($urandom());
            end
        endcase
        return v;
    endfunction

    // Offers one input transaction and waits until it is accepted. The valid
    // is raised at this edge; acceptance is seen at a later edge where ready
    // was high. The expectation is queued at that edge, either typed in by the
    // caller or worked out by the predictor, which is stepped in both cases.
    // Afterward the sender may go idle for a random burst.
    task automatic send_sample(input logic [SBITS-1:0] s, input logic sn,
                               input bit use_typed, input t_median_result typed);
        t_median_result predicted;
        i_sample    <= s;
        i_start_new <= sn;
        i_in_valid  <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted = next_median(s, sn);
        pending_medians.push_back(use_typed ? typed : predicted);
        samples_sent++;
        if (sn) begin
            restarts_sent++;
        end
        if (!quiet_tail && !hold_request && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Receiver side. It normally takes results at once, stalls now and then
    // for a random burst, and once on request holds off for a long stretch
    // so the block backs up and stops accepting samples.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checker. Outputs are sampled at the clock edge, so a result
    // transaction is one where valid and ready were both high just before it.
    always @(posedge i_clk) begin
        t_median_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_medians.size() == 0) begin
                flag_error($sformatf("result with no sample outstanding: median %0d count %0d",
                                     $signed(o_median), o_held_count));
            end else begin
                want = pending_medians.pop_front();
                results_checked++;
                if (o_full_res === 1'b1) begin
                    drops_seen++;
                end
                if (o_median !== want.median) begin
                    flag_error($sformatf("median %0d, expected %0d (result %0d)",
                                         $signed(o_median), want.median, results_checked));
                end
                if (o_held_count !== want.held_count) begin
                    flag_error($sformatf("held_count %0d, expected %0d (result %0d)",
                                         o_held_count, want.held_count, results_checked));
                end
                if (o_full_res !== want.full_res) begin
                    flag_error($sformatf("full_res %b, expected %b (result %0d)",
                                         o_full_res, want.full_res, results_checked));
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel completes a transaction for
    // far longer than the longest legal stall.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        flag_error($sformatf("no transaction for %0d cycles, %0d results outstanding",
                             WATCHDOG_LIMIT, pending_medians.size()));
        $display("Mismatches found");
        $finish;
    end

    // Main stimulus: reset, the directed table, then random sample sets.
    initial begin
        t_median_result typed;
        t_spread        spread;
        int             set_len;
        int             rand_sent;
        bit             drained;
        logic           sn;

        rand_sent = 0;
        drained   = 1'b0;

        // Synchronous reset, released at a clock edge.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            typed.median     = directed_rows[i].med;
            typed.held_count = directed_rows[i].cnt;
            typed.full_res   = directed_rows[i].full;
            for (int r = 0; r < directed_rows[i].reps; r++) begin
                sn = (r == 0) ? directed_rows[i].start_new : 1'b0;
                send_sample(directed_rows[i].sample, sn, directed_rows[i].known, typed);
            end
        end

        // Random part. Most sets are well formed: they open with a restart and
        // continue with plain samples. About a quarter of them run 56 to 72 samples,
        // so many fill the store and drops and restarts on a full store recur. Now
        // and then a set opens without a restart, or a restart lands mid-set.
        while (rand_sent < RANDOM_ITEMS) begin
            spread  = t_spread'($urandom_range(0, 2));
            set_len = ($urandom_range(0, 3) == 0) ? $urandom_range(56, 72)
                                                  : $urandom_range(1, 24);
            for (int k = 0; k < set_len && rand_sent < RANDOM_ITEMS; k++) begin
                if (k == 0) begin
                    sn = ($urandom_range(0, 7) != 0);
                end else begin
                    sn = ($urandom_range(0, 31) == 0);
                end
                if (rand_sent == HOLD_AT_ITEM) begin
                    hold_request = 1'b1;
                end
                quiet_tail = (rand_sent >= RANDOM_ITEMS - QUIET_TAIL);
                send_sample(pick_sample(spread), sn, 1'b0, typed);
                rand_sent++;

                // Once, stop offering and let every outstanding result drain.
                if (!drained && rand_sent >= DRAIN_AT_ITEM) begin
                    drained = 1'b1;
                    i_in_valid <= 1'b0;
                    do begin
                        @(posedge i_clk);
                    end while (pending_medians.size() != 0);
                end
            end
        end
        i_in_valid <= 1'b0;

        // Let the last results arrive, then watch a little longer for extras.
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_medians.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", pending_medians.size()));
        end

        $display("Sent %0d samples (%0d restarts) and checked %0d results, %0d of them drops.",
                 samples_sent, restarts_sent, results_checked, drops_seen);
        $display("Covered extreme values, equal samples, full-store drops and long back-pressure.");
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/runmed_pkg.sv
rtl/core/runmed_cell.sv
rtl/core/runmed_select.sv
rtl/core/running_median_top.sv
rtl/core/runmed_checker.sv
tb/sv/tb.sv
